/* rtl/pcs_pkg.sv */
`default_nettype none
package pcs_pkg;

  localparam int unsigned PaletteDepth = 16;
  localparam int unsigned IdxW = 4;
  localparam int unsigned LenW = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    OpTick  = 2'd0,
    OpLoadA = 2'd1,
    OpLoadB = 2'd2,
    OpRestart = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    RegTotalSteps = 3'd0,
    RegRateTicks  = 3'd1,
    RegPauseTicks = 3'd2,
    RegStartPaused = 3'd3,
    RegLooped     = 3'd4,
    RegEnable     = 3'd5,
    RegStartLen   = 3'd6,
    RegEndLen     = 3'd7
  } reg_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  entry_index;
    logic [23:0] color_in;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  out_index;
    logic [23:0] blended_color;
    logic [7:0]  ratio;
    logic        last;
  } out_item_t;

  // One emit job passed from the front to the back.
  typedef struct packed {
    logic [7:0]      ratio;
    logic            swapped;
    logic [LenW-1:0] len_a;
    logic [LenW-1:0] len_b;
  } job_t;

  function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] n);
    logic [LenW-1:0] r;
    r = n;
    if (n == '0) r = LenW'(1);
    else if (n > LenW'(PaletteDepth)) r = LenW'(PaletteDepth);
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/pcs_ram.sv */
`default_nettype none
module pcs_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* rtl/pcs_front.sv */
`default_nettype none
module pcs_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_idx_i,
  input  wire logic [15:0]       cfg_data_i,
  input  wire logic              item_valid_i,
  output logic                   item_ready_o,
  input  wire pcs_pkg::in_item_t item_i,
  output logic                   job_valid_o,
  input  wire logic              job_ready_i,
  output pcs_pkg::job_t          job_o,
  output logic                   we_a_o,
  output logic                   we_b_o
);
  logic [7:0]  total_q, step_q, step_d;
  logic [15:0] rate_q, pause_q, rel_q, rel_d, pel_q, pel_d;
  logic        sp_q, loop_q, en_q, swp_q, swp_d, pa_q, pa_d, pf_q, pf_d;
  logic [pcs_pkg::LenW-1:0] la_q, lb_q;
  logic [7:0]  tot, st;
  logic [15:0] prod;
  logic        fire, emit, go, end_swap, is_load;
  // ratio quotient by iterative restoring division
  logic        div_busy_q;
  logic [3:0]  div_cnt_q;
  logic [15:0] rem_q;
  logic [7:0]  quo_q;
  logic        div_swp_q;
  logic [15:0] num_q;
  logic [16:0] trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= 8'd1; rate_q <= '0; pause_q <= '0; sp_q <= 1'b0;
      loop_q <= 1'b0; en_q <= 1'b0; la_q <= 5'd1; lb_q <= 5'd1;
    end else if (cfg_we_i) begin
      unique case (pcs_pkg::reg_e'(cfg_idx_i))
        pcs_pkg::RegTotalSteps:  total_q <= cfg_data_i[7:0];
        pcs_pkg::RegRateTicks:   rate_q <= cfg_data_i;
        pcs_pkg::RegPauseTicks:  pause_q <= cfg_data_i;
        pcs_pkg::RegStartPaused: sp_q <= cfg_data_i[0];
        pcs_pkg::RegLooped:      loop_q <= cfg_data_i[0];
        pcs_pkg::RegEnable:      en_q <= cfg_data_i[0];
        pcs_pkg::RegStartLen:    la_q <= cfg_data_i[4:0];
        pcs_pkg::RegEndLen:      lb_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // hold loads while the back still reads the palettes
  assign is_load = (item_i.op == pcs_pkg::OpLoadA) || (item_i.op == pcs_pkg::OpLoadB);
  assign item_ready_o = !div_busy_q && !job_valid_o && (job_ready_i || !is_load);
  assign fire = item_valid_i && item_ready_o;
  assign we_a_o = fire && (item_i.op == pcs_pkg::OpLoadA);
  assign we_b_o = fire && (item_i.op == pcs_pkg::OpLoadB);
  assign tot = (total_q == '0) ? 8'd1 : total_q;

  always_comb begin
    step_d = step_q; swp_d = swp_q; pa_d = pa_q; pf_d = pf_q;
    rel_d = rel_q; pel_d = pel_q; emit = 1'b0; go = 1'b1; st = '0;
    end_swap = 1'b0;
    if (fire && item_i.op == pcs_pkg::OpTick) begin
      if (rel_d != 16'hFFFF) rel_d = rel_d + 16'd1;
      if (pa_d && pel_d != 16'hFFFF) pel_d = pel_d + 16'd1;
      if (en_q && rel_d >= rate_q) begin
        rel_d = '0;
        if (sp_q && !pf_d && !pa_d) begin
          pa_d = 1'b1; pel_d = '0;
        end
        if (pa_d) begin
          if (pel_d < pause_q) go = 1'b0;
          else begin
            pa_d = 1'b0; pf_d = 1'b1;
            if (!sp_q && loop_q) begin
              swp_d = !swp_d; step_d = '0; pa_d = 1'b0; pf_d = 1'b0; pel_d = '0;
            end
          end
        end
        if (go) begin
          if (step_d < tot) step_d = step_d + 8'd1;
          st = (step_d > tot) ? tot : step_d;
          emit = 1'b1;
          // emit uses current swap; later swap only affects the next job
          if (step_d >= tot) begin
            if (!sp_q && !pf_d) begin
              pa_d = 1'b1; pel_d = '0;
            end else if (loop_q) begin
              step_d = '0; pa_d = 1'b0; pf_d = 1'b0; pel_d = '0;
              end_swap = 1'b1;
            end
          end
        end
      end
    end else if (fire && item_i.op == pcs_pkg::OpRestart) begin
      step_d = '0; pa_d = 1'b0; pf_d = 1'b0; pel_d = '0; emit = 1'b1;
    end
  end

  // swap flip at end of blend happens after the emit; tracked separately
  logic swp_emit, swp_end;
  always_comb begin
    swp_emit = swp_d;
    swp_end = swp_d ^ end_swap;
  end

  assign prod = {8'd0, st} * 16'd255;
  assign trial = {rem_q, num_q[15]} - {9'd0, tot};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0; swp_q <= 1'b0; pa_q <= 1'b0; pf_q <= 1'b0;
      rel_q <= '0; pel_q <= '0; div_busy_q <= 1'b0; job_valid_o <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      step_q <= step_d; swp_q <= swp_end; pa_q <= pa_d; pf_q <= pf_d;
      rel_q <= rel_d; pel_q <= pel_d;
      if (job_valid_o && job_ready_i) job_valid_o <= 1'b0;
      if (emit) begin
        div_busy_q <= 1'b1; div_cnt_q <= 4'd0;
      end else if (div_busy_q) begin
        div_cnt_q <= div_cnt_q + 4'd1;
        if (div_cnt_q == 4'd15) begin
          div_busy_q <= 1'b0; job_valid_o <= 1'b1;
        end
      end
    end
  end

  // bit-serial quotient: remainder shifts in one product bit per cycle
  always_ff @(posedge clk_i) begin
    if (emit) begin
      num_q <= prod; rem_q <= '0; quo_q <= '0; div_swp_q <= swp_emit;
    end else if (div_busy_q) begin
      num_q <= {num_q[14:0], 1'b0};
      if (!trial[16]) begin
        rem_q <= trial[15:0];
        quo_q <= {quo_q[6:0], 1'b1};
      end else begin
        rem_q <= {rem_q[14:0], num_q[15]};
        quo_q <= {quo_q[6:0], 1'b0};
      end
    end
  end

  assign job_o.ratio = quo_q;
  assign job_o.swapped = div_swp_q;
  assign job_o.len_a = pcs_pkg::clamp_len(la_q);
  assign job_o.len_b = pcs_pkg::clamp_len(lb_q);
endmodule
`default_nettype wire

/* rtl/pcs_back.sv */
`default_nettype none
module pcs_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               job_valid_i,
  output logic                    job_ready_o,
  input  wire pcs_pkg::job_t      job_i,
  output logic [3:0]              ra_addr_o,
  output logic [3:0]              rb_addr_o,
  input  wire logic [23:0]        ra_data_i,
  input  wire logic [23:0]        rb_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output pcs_pkg::out_item_t      out_o
);
  pcs_pkg::job_t job_q;
  logic       busy_q, rd_q, rd_last_q;
  logic [4:0] i_q, ia_q, ib_q, n;
  logic [3:0] rd_idx_q;
  logic [23:0] s, e, c;
  logic [4:0] ls, le;
  logic issue;

  assign n = (job_q.len_a > job_q.len_b) ? job_q.len_a : job_q.len_b;
  assign ls = job_q.swapped ? job_q.len_b : job_q.len_a;
  assign le = job_q.swapped ? job_q.len_a : job_q.len_b;
  assign job_ready_o = !busy_q;
  // no read in flight and an empty or draining output register before issuing
  assign issue = busy_q && !rd_q && (!out_valid_o || out_ready_i);
  assign ra_addr_o = job_q.swapped ? ib_q[3:0] : ia_q[3:0];
  assign rb_addr_o = job_q.swapped ? ia_q[3:0] : ib_q[3:0];

  assign s = job_q.swapped ? rb_data_i : ra_data_i;
  assign e = job_q.swapped ? ra_data_i : rb_data_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c[k*8 +: 8] = 8'((({8'd0, s[k*8 +: 8]} * 16'(8'd255 - job_q.ratio)
                        + {8'd0, e[k*8 +: 8]} * 16'(job_q.ratio)) * 32'd32897) >> 23);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; rd_q <= 1'b0; out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (job_valid_i && !busy_q) begin
        busy_q <= 1'b1;
      end
      rd_q <= issue;
      if (rd_q) out_valid_o <= 1'b1;
      if (issue && i_q + 5'd1 == n) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i && !busy_q) begin
      job_q <= job_i; i_q <= '0; ia_q <= '0; ib_q <= '0;
    end else if (issue) begin
      i_q <= i_q + 5'd1;
      ia_q <= (ia_q + 5'd1 == ls) ? 5'd0 : ia_q + 5'd1;
      ib_q <= (ib_q + 5'd1 == le) ? 5'd0 : ib_q + 5'd1;
    end
    if (issue) begin
      rd_idx_q <= i_q[3:0]; rd_last_q <= (i_q + 5'd1 == n);
    end
    if (rd_q) begin
      out_o.out_index <= rd_idx_q;
      out_o.blended_color <= c;
      out_o.ratio <= job_q.ratio;
      out_o.last <= rd_last_q;
    end
  end
endmodule
`default_nettype wire

/* rtl/palette_crossfade_sequencer.sv */
`default_nettype none
// Palette crossfade sequencer.
// Input channel (item_valid_i/item_ready_o, item_i): op tick, load start
// colour, load end colour, restart. Loads write a palette RAM and give no
// beat. A tick that updates, and every restart, produces a run of
// max(start_length, end_length) output beats on out_valid_o/out_ready_i,
// the final one flagged by last.
// Configuration: cfg_we_i writes register cfg_idx_i with cfg_data_i, taken
// at once; write only while idle.
// The ratio is formed by a shift-subtract divider in the front, then the
// job crosses to the back, which reads both palette RAMs one entry at a
// time and issues the next read only once the previous one has reached
// the output register.
// Items are taken one at a time: the input is held off while the divider
// runs or a job waits for the back, and a load also waits until the back
// has read its last entry.
// Reset clears the step, pause and swap state and the registers to their
// defaults; palette contents are undefined until loaded.
// When the receiver stalls, the back holds its output beat and stops
// reading, and the front stalls once its job slot is full.
module palette_crossfade_sequencer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               item_valid_i,
  output logic                    item_ready_o,
  input  wire pcs_pkg::in_item_t  item_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output pcs_pkg::out_item_t      out_o
);
  logic job_valid, job_ready, we_a, we_b;
  pcs_pkg::job_t job;
  logic [3:0] ra_addr, rb_addr;
  logic [23:0] ra_data, rb_data;

  pcs_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .item_valid_i, .item_ready_o, .item_i,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job),
    .we_a_o(we_a), .we_b_o(we_b)
  );

  pcs_ram #(.Width(24), .Depth(pcs_pkg::PaletteDepth)) u_ram_a (
    .clk_i, .we_i(we_a), .waddr_i(item_i.entry_index), .wdata_i(item_i.color_in),
    .raddr_i(ra_addr), .rdata_o(ra_data)
  );

  pcs_ram #(.Width(24), .Depth(pcs_pkg::PaletteDepth)) u_ram_b (
    .clk_i, .we_i(we_b), .waddr_i(item_i.entry_index), .wdata_i(item_i.color_in),
    .raddr_i(rb_addr), .rdata_o(rb_data)
  );

  pcs_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .ra_addr_o(ra_addr), .rb_addr_o(rb_addr), .ra_data_i(ra_data), .rb_data_i(rb_data),
    .out_valid_o, .out_ready_i, .out_o
  );

`ifndef SYNTHESIS
  a_no_take_while_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid |-> !item_ready_o) else $error("item taken with job pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("output beat dropped");
`endif
endmodule
`default_nettype wire
